// ===== rtl/coapo_pkg.sv =====
// Shared types and codes for the CoAP option parser.
// Used by coapo_decode and coap_option_parser; no dependencies.
package coapo_pkg;

    localparam logic [7:0]  OPTIONS_END    = 8'hFF;
    localparam logic [3:0]  NIB_EXT1       = 4'd13;
    localparam logic [3:0]  NIB_EXT2       = 4'd14;
    localparam logic [3:0]  NIB_RESERVED   = 4'd15;
    localparam logic [16:0] EXT1_OFFSET    = 17'd13;
    localparam logic [16:0] EXT2_OFFSET    = 17'd269;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_DELTA_EXT = 3'd1,
        PH_LEN_EXT   = 3'd2,
        PH_VALUE     = 3'd3,
        PH_STOPPED   = 3'd4
    } coapo_phase_t;

    typedef enum logic [2:0] {
        K_HEAD    = 3'd0,
        K_VALUE   = 3'd1,
        K_EMPTY   = 3'd2,
        K_MARKER  = 3'd3,
        K_ERROR   = 3'd4,
        K_IGNORED = 3'd5
    } coapo_kind_t;

    typedef struct packed {
        coapo_phase_t phase;
        logic [3:0]   delta_nibble;
        logic [3:0]   length_nibble;
        logic [15:0]  ext_delta;
        logic [15:0]  ext_length;
        logic         ext_second_byte;
        logic [15:0]  running_number;
        logic [16:0]  remaining_bytes;
    } coapo_state_t;

    typedef struct packed {
        coapo_kind_t kind;
        logic [15:0] option_number;
        logic [16:0] option_length;
        logic [7:0]  value_byte;
        logic        last_of_option;
    } coapo_result_t;

    localparam coapo_state_t STATE_RESET = '{
        phase:           PH_HEADER,
        delta_nibble:    4'd0,
        length_nibble:   4'd0,
        ext_delta:       16'd0,
        ext_length:      16'd0,
        ext_second_byte: 1'b0,
        running_number:  16'd0,
        remaining_bytes: 17'd0
    };

endpackage

// ===== rtl/coapo_decode.sv =====
// Per-byte decode step: next parse state and result word for one option byte.
// Purely combinational; depends on coapo_pkg.
module coapo_decode
    import coapo_pkg::*;
(
    input  coapo_state_t  state,
    input  logic [7:0]    in_byte,
    input  logic          start_of_options,
    output coapo_state_t  state_next,
    output coapo_result_t result
);

    always_comb
    begin
        coapo_state_t st;
        logic         do_delta;
        logic         do_begin;
        logic         do_len;
        logic [16:0]  delta_val;
        logic [16:0]  len_val;
        logic [17:0]  sum;
        logic [16:0]  cur_len;

        st        = start_of_options ? STATE_RESET : state;
        state_next = st;
        result    = '0;
        result.kind = K_HEAD;
        do_delta  = 1'b0;
        do_begin  = 1'b0;
        do_len    = 1'b0;
        delta_val = '0;
        len_val   = '0;
        sum       = '0;
        cur_len   = '0;

        unique case (st.phase)
            PH_HEADER:
            begin
                if (in_byte == OPTIONS_END)
                begin
                    state_next.phase = PH_STOPPED;
                    result.kind      = K_MARKER;
                end
                else
                begin
                    state_next.delta_nibble    = in_byte[7:4];
                    state_next.length_nibble   = in_byte[3:0];
                    state_next.ext_delta       = '0;
                    state_next.ext_length      = '0;
                    state_next.ext_second_byte = 1'b0;
                    if (in_byte[7:4] == NIB_RESERVED || in_byte[3:0] == NIB_RESERVED)
                    begin
                        state_next.phase = PH_STOPPED;
                        result.kind      = K_ERROR;
                    end
                    else if (in_byte[7:4] >= NIB_EXT1)
                    begin
                        state_next.phase = PH_DELTA_EXT;
                    end
                    else
                    begin
                        do_delta  = 1'b1;
                        delta_val = {13'd0, in_byte[7:4]};
                    end
                end
            end
            PH_DELTA_EXT:
            begin
                if (st.delta_nibble == NIB_EXT1)
                begin
                    state_next.ext_delta = {8'd0, in_byte};
                    do_delta  = 1'b1;
                    delta_val = {9'd0, in_byte} + EXT1_OFFSET;
                end
                else if (!st.ext_second_byte)
                begin
                    state_next.ext_delta       = {in_byte, 8'd0};
                    state_next.ext_second_byte = 1'b1;
                end
                else
                begin
                    state_next.ext_delta       = {st.ext_delta[15:8], in_byte};
                    state_next.ext_second_byte = 1'b0;
                    do_delta  = 1'b1;
                    delta_val = {1'b0, st.ext_delta[15:8], in_byte} + EXT2_OFFSET;
                end
            end
            PH_LEN_EXT:
            begin
                if (st.length_nibble == NIB_EXT1)
                begin
                    state_next.ext_length = {8'd0, in_byte};
                    do_len  = 1'b1;
                    len_val = {9'd0, in_byte} + EXT1_OFFSET;
                end
                else if (!st.ext_second_byte)
                begin
                    state_next.ext_length      = {in_byte, 8'd0};
                    state_next.ext_second_byte = 1'b1;
                end
                else
                begin
                    state_next.ext_length      = {st.ext_length[15:8], in_byte};
                    state_next.ext_second_byte = 1'b0;
                    do_len  = 1'b1;
                    len_val = {1'b0, st.ext_length[15:8], in_byte} + EXT2_OFFSET;
                end
            end
            PH_VALUE:
            begin
                if (st.length_nibble < NIB_EXT1)
                    cur_len = {13'd0, st.length_nibble};
                else if (st.length_nibble == NIB_EXT1)
                    cur_len = {1'b0, st.ext_length} + EXT1_OFFSET;
                else
                    cur_len = {1'b0, st.ext_length} + EXT2_OFFSET;
                if (st.remaining_bytes != '0)
                    state_next.remaining_bytes = st.remaining_bytes - 17'd1;
                result.kind          = K_VALUE;
                result.option_length = cur_len;
                result.value_byte    = in_byte;
                if (state_next.remaining_bytes == '0)
                begin
                    state_next.phase      = PH_HEADER;
                    result.last_of_option = 1'b1;
                end
            end
            default:
            begin
                state_next.phase = PH_STOPPED;
                result.kind      = K_IGNORED;
            end
        endcase

        // add the delta; anything past 16 bits is a number overflow
        if (do_delta)
        begin
            sum = {2'd0, st.running_number} + {1'b0, delta_val};
            if (sum[17:16] != 2'd0)
            begin
                state_next.phase = PH_STOPPED;
                result.kind      = K_ERROR;
            end
            else
            begin
                state_next.running_number = sum[15:0];
                do_begin = 1'b1;
            end
        end

        if (do_begin)
        begin
            if (state_next.length_nibble < NIB_EXT1)
            begin
                do_len  = 1'b1;
                len_val = {13'd0, state_next.length_nibble};
            end
            else
            begin
                state_next.phase           = PH_LEN_EXT;
                state_next.ext_second_byte = 1'b0;
            end
        end

        if (do_len)
        begin
            if (len_val == '0)
            begin
                state_next.phase      = PH_HEADER;
                result.kind           = K_EMPTY;
                result.last_of_option = 1'b1;
            end
            else
            begin
                state_next.phase           = PH_VALUE;
                state_next.remaining_bytes = len_val;
                result.option_length       = len_val;
            end
        end

        result.option_number = state_next.running_number;
    end

endmodule

// ===== rtl/coap_option_parser.sv =====
// An accepted option byte's result word is registered and shown on the master side next cycle.
// Throughput: one byte per cycle while m_tready keeps the result register draining;
// the parse state registers update on every accepted byte, so input and output overlap.
// Reset (rst_n low, asynchronous): parser expects an option header, running option
// number is zero, no result word is pending.
// Depends on coapo_pkg and coapo_decode.
module coap_option_parser
    import coapo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] start_of_options
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] option_number, [32:16] option_length,
                                   // [40:33] value_byte, [47:41] zero
    output logic [2:0]  m_tuser,   // [2:0] byte_kind
    output logic        m_tlast    // last_of_option
);

    coapo_state_t  state_reg;
    coapo_state_t  state_next;
    coapo_result_t result_next;
    coapo_result_t result_reg;
    logic          m_tvalid_reg;
    logic          s_accept;

    // take a new word whenever the result register is empty or drains this cycle
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    coapo_decode u_decode (
        .state            (state_reg),
        .in_byte          (s_tdata),
        .start_of_options (s_tuser),
        .state_next       (state_next),
        .result           (result_next)
    );

    // parse state advances only on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= STATE_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload: load on accept, hold while stalled
    always_ff @(posedge clk)
    begin
        if (s_accept)
            result_reg <= result_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, result_reg.value_byte, result_reg.option_length,
                       result_reg.option_number};
    assign m_tuser  = result_reg.kind;
    assign m_tlast  = result_reg.last_of_option;

endmodule

// ===== tb/sv/tb_coap_option_parser.sv =====
// Self-checking testbench for coap_option_parser: random and directed option bytes,
// a local parser model predicting each result word, stalls on both stream sides.
// Depends on coapo_pkg and the RTL of coap_option_parser.
`timescale 1ns / 1ps

module tb_coap_option_parser
    import coapo_pkg::*;
();

    typedef struct packed {
        logic [7:0] data;
        logic       sop;
    } option_byte_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [7:0] in_byte
    logic        s_tuser  = 1'b0;   // [0] start_of_options
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // [15:0] option_number, [32:16] option_length,
                                    // [40:33] value_byte, [47:41] zero
    logic [2:0]  m_tuser;           // [2:0] byte_kind
    logic        m_tlast;           // last_of_option

    option_byte_t  pending_bytes[$];
    coapo_result_t expected_words[$];

    int src_wait    = 0;
    int snk_wait    = 0;
    int src_calm    = 0;
    int snk_calm    = 0;
    int bytes_taken = 0;
    int hold_left   = 0;
    int holds_done  = 0;
    int mismatches  = 0;

    // Parser model state
    coapo_phase_t pr_phase;
    logic [3:0]   pr_delta_nib;
    logic [3:0]   pr_len_nib;
    logic [15:0]  pr_ext_delta;
    logic [15:0]  pr_ext_len;
    logic         pr_ext_second;
    logic [15:0]  pr_number;
    logic [16:0]  pr_remaining;

    coap_option_parser u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    task automatic clear_parser();
        pr_phase      = PH_HEADER;
        pr_delta_nib  = 4'd0;
        pr_len_nib    = 4'd0;
        pr_ext_delta  = 16'd0;
        pr_ext_len    = 16'd0;
        pr_ext_second = 1'b0;
        pr_number     = 16'd0;
        pr_remaining  = 17'd0;
    endtask

    // Build a result word tagged with the current running option number.
    function automatic coapo_result_t result_word(coapo_kind_t kind, logic [16:0] len,
                                                  logic [7:0] val, logic last);
        coapo_result_t r;
        r.kind           = kind;
        r.option_number  = pr_number;
        r.option_length  = len;
        r.value_byte     = val;
        r.last_of_option = last;
        return r;
    endfunction

    // A zero length closes the option on the spot; otherwise value bytes follow.
    task automatic finish_length(input logic [16:0] len, output coapo_result_t r);
        if (len == 17'd0)
        begin
            pr_phase = PH_HEADER;
            r = result_word(K_EMPTY, 17'd0, 8'd0, 1'b1);
        end
        else
        begin
            pr_phase     = PH_VALUE;
            pr_remaining = len;
            r = result_word(K_HEAD, len, 8'd0, 1'b0);
        end
    endtask

    // Accumulate the delta, flag overflow past 16 bits, then move on to the length.
    task automatic add_delta(input logic [16:0] delta, output coapo_result_t r);
        logic [17:0] sum;
        sum = {2'b00, pr_number} + {1'b0, delta};
        if (sum > 18'h0FFFF)
        begin
            pr_phase = PH_STOPPED;
            r = result_word(K_ERROR, 17'd0, 8'd0, 1'b0);
        end
        else
        begin
            pr_number = sum[15:0];
            if (pr_len_nib < NIB_EXT1)
                finish_length({13'd0, pr_len_nib}, r);
            else
            begin
                pr_phase      = PH_LEN_EXT;
                pr_ext_second = 1'b0;
                r = result_word(K_HEAD, 17'd0, 8'd0, 1'b0);
            end
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic sop, output coapo_result_t r);
        logic [16:0] len;
        if (sop)
            clear_parser();
        case (pr_phase)
            PH_HEADER:
                if (b == OPTIONS_END)
                begin
                    pr_phase = PH_STOPPED;
                    r = result_word(K_MARKER, 17'd0, 8'd0, 1'b0);
                end
                else
                begin
                    pr_delta_nib  = b[7:4];
                    pr_len_nib    = b[3:0];
                    pr_ext_delta  = 16'd0;
                    pr_ext_len    = 16'd0;
                    pr_ext_second = 1'b0;
                    if (pr_delta_nib == NIB_RESERVED || pr_len_nib == NIB_RESERVED)
                    begin
                        pr_phase = PH_STOPPED;
                        r = result_word(K_ERROR, 17'd0, 8'd0, 1'b0);
                    end
                    else if (pr_delta_nib >= NIB_EXT1)
                    begin
                        pr_phase = PH_DELTA_EXT;
                        r = result_word(K_HEAD, 17'd0, 8'd0, 1'b0);
                    end
                    else
                        add_delta({13'd0, pr_delta_nib}, r);
                end
            PH_DELTA_EXT:
                if (pr_delta_nib == NIB_EXT1)
                begin
                    pr_ext_delta = {8'd0, b};
                    add_delta({9'd0, b} + EXT1_OFFSET, r);
                end
                else if (!pr_ext_second)
                begin
                    pr_ext_delta  = {b, 8'd0};
                    pr_ext_second = 1'b1;
                    r = result_word(K_HEAD, 17'd0, 8'd0, 1'b0);
                end
                else
                begin
                    pr_ext_delta  = pr_ext_delta | {8'd0, b};
                    pr_ext_second = 1'b0;
                    add_delta({1'b0, pr_ext_delta} + EXT2_OFFSET, r);
                end
            PH_LEN_EXT:
                if (pr_len_nib == NIB_EXT1)
                begin
                    pr_ext_len = {8'd0, b};
                    finish_length({9'd0, b} + EXT1_OFFSET, r);
                end
                else if (!pr_ext_second)
                begin
                    pr_ext_len    = {b, 8'd0};
                    pr_ext_second = 1'b1;
                    r = result_word(K_HEAD, 17'd0, 8'd0, 1'b0);
                end
                else
                begin
                    pr_ext_len    = pr_ext_len | {8'd0, b};
                    pr_ext_second = 1'b0;
                    finish_length({1'b0, pr_ext_len} + EXT2_OFFSET, r);
                end
            PH_VALUE:
            begin
                if (pr_len_nib < NIB_EXT1)
                    len = {13'd0, pr_len_nib};
                else if (pr_len_nib == NIB_EXT1)
                    len = {1'b0, pr_ext_len} + EXT1_OFFSET;
                else
                    len = {1'b0, pr_ext_len} + EXT2_OFFSET;
                if (pr_remaining != 17'd0)
                    pr_remaining = pr_remaining - 17'd1;
                if (pr_remaining == 17'd0)
                begin
                    pr_phase = PH_HEADER;
                    r = result_word(K_VALUE, len, b, 1'b1);
                end
                else
                    r = result_word(K_VALUE, len, b, 1'b0);
            end
            default:
            begin
                pr_phase = PH_STOPPED;
                r = result_word(K_IGNORED, 17'd0, 8'd0, 1'b0);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] data, input logic sop);
        option_byte_t item;
        item.data = data;
        item.sop  = sop;
        pending_bytes.push_back(item);
    endtask

    function automatic logic [3:0] nibble_for(logic [16:0] v);
        if (v < EXT1_OFFSET)
            return v[3:0];
        else if (v < EXT2_OFFSET)
            return NIB_EXT1;
        else
            return NIB_EXT2;
    endfunction

    // Encode one well-formed option: header, extensions, random value bytes.
    task automatic queue_option(input logic sop, input logic [16:0] delta,
                                input logic [16:0] len);
        logic [3:0]  dn;
        logic [3:0]  ln;
        logic [16:0] dx;
        logic [16:0] lx;
        dn = nibble_for(delta);
        ln = nibble_for(len);
        dx = delta - ((dn == NIB_EXT1) ? EXT1_OFFSET : EXT2_OFFSET);
        lx = len - ((ln == NIB_EXT1) ? EXT1_OFFSET : EXT2_OFFSET);
        queue_byte({dn, ln}, sop);
        if (dn == NIB_EXT1)
            queue_byte(dx[7:0], 1'b0);
        else if (dn == NIB_EXT2)
        begin
            queue_byte(dx[15:8], 1'b0);
            queue_byte(dx[7:0], 1'b0);
        end
        if (ln == NIB_EXT1)
            queue_byte(lx[7:0], 1'b0);
        else if (ln == NIB_EXT2)
        begin
            queue_byte(lx[15:8], 1'b0);
            queue_byte(lx[7:0], 1'b0);
        end
        repeat (len)
            queue_byte(8'($urandom), 1'b0);
    endtask

    // Random per-word wait, with occasional stretches of back-to-back words.
    task automatic draw_wait(inout int calm, output int w);
        if (calm > 0)
        begin
            calm = calm - 1;
            w = 0;
        end
        else
        begin
            w = $urandom_range(0, 7);
            if ($urandom_range(0, 39) == 0)
                calm = 25;
        end
    endtask

    // ------------------------------------------------------------------
    // Source side: offer queued bytes, predict each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : byte_source
        coapo_result_t predicted;
        option_byte_t  taken;
        int            w;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'd0;
            s_tuser  <= 1'b0;
            src_wait <= 0;
        end
        else
        begin
            w = src_wait;
            if (s_tvalid && s_tready)
            begin
                taken = pending_bytes.pop_front();
                parse_byte(taken.data, taken.sop, predicted);
                expected_words.push_back(predicted);
                bytes_taken <= bytes_taken + 1;
                draw_wait(src_calm, w);
            end
            // Hold the word while it is refused; otherwise idle or offer the next one.
            if (!s_tvalid || s_tready)
            begin
                if (w > 0)
                begin
                    w = w - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_bytes[0].data;
                    s_tuser  <= pending_bytes[0].sop;
                end
                else
                    s_tvalid <= 1'b0;
            end
            src_wait <= w;
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-offs: let the result register fill and back up the input
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            holds_done <= 0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (holds_done < 2 && bytes_taken >= 200 + 300 * holds_done)
        begin
            hold_left  <= 90;
            holds_done <= holds_done + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sink side: take result words, compare against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : word_sink
        coapo_result_t want;
        int            w;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_wait <= 0;
        end
        else
        begin
            w = snk_wait;
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected word: kind %0d number %0d length %0d value %0h last %0b",
                                 m_tuser, m_tdata[15:0], m_tdata[32:16], m_tdata[40:33],
                                 m_tlast);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (m_tuser !== want.kind || m_tdata[15:0] !== want.option_number ||
                        m_tdata[32:16] !== want.option_length ||
                        m_tdata[40:33] !== want.value_byte || m_tlast !== want.last_of_option)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                        begin
                            $display("word mismatch at %0t ns", $realtime);
                            $display("  expected kind %0d number %0d length %0d value %0h last %0b",
                                     want.kind, want.option_number, want.option_length,
                                     want.value_byte, want.last_of_option);
                            $display("  actual   kind %0d number %0d length %0d value %0h last %0b",
                                     m_tuser, m_tdata[15:0], m_tdata[32:16], m_tdata[40:33],
                                     m_tlast);
                        end
                    end
                end
                draw_wait(snk_calm, w);
            end
            else if (w > 0)
                w = w - 1;
            snk_wait <= w;
            m_tready <= (w == 0) && (hold_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int          i;
        int          n;
        int          roll;
        logic [16:0] d;
        logic [16:0] l;

        clear_parser();

        // No start seen: parse straight after reset, delta 1, one value byte.
        queue_byte(8'h11, 1'b0);
        queue_byte(8'hAA, 1'b0);
        // Empty option with zero delta.
        queue_byte(8'h00, 1'b1);
        // One-byte delta extension at its top value, value byte of all ones.
        queue_byte(8'hD1, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        // Largest two-byte length, then abandon the option with a new start.
        queue_byte(8'h0E, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h5A, 1'b0);
        // Payload marker right at the start, then ignored bytes.
        queue_byte(OPTIONS_END, 1'b1);
        queue_byte(8'h12, 1'b0);
        // Reserved delta nibble, then ignored.
        queue_byte(8'hF0, 1'b1);
        queue_byte(8'h00, 1'b0);
        // Reserved length nibble.
        queue_byte(8'h0F, 1'b1);
        // Two-byte delta up to the top option number, then overflow by one.
        queue_byte(8'hE0, 1'b1);
        queue_byte(8'hFE, 1'b0);
        queue_byte(8'hF2, 1'b0);
        queue_byte(8'h10, 1'b0);
        // Largest two-byte delta overflows from zero.
        queue_byte(8'hE0, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        // Shortest one-byte length extension.
        queue_option(1'b1, 17'd0, 17'd13);

        // Random sections: mostly well-formed option runs, some noise.
        while (pending_bytes.size() < 740)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 85)
            begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                begin
                    roll = $urandom_range(0, 9);
                    if (roll < 7)
                        d = 17'($urandom_range(0, 12));
                    else if (roll < 9)
                        d = 17'(13 + $urandom_range(0, 255));
                    else if ($urandom_range(0, 7) == 0)
                        d = 17'(269 + $urandom_range(0, 65535));
                    else
                        d = 17'(269 + $urandom_range(0, 2000));
                    roll = $urandom_range(0, 99);
                    if (roll < 75)
                        l = 17'($urandom_range(0, 12));
                    else if (roll < 99)
                        l = 17'(13 + $urandom_range(0, 7));
                    else
                        l = 17'(269 + $urandom_range(0, 3));
                    queue_option(i == 0, d, l);
                end
                if ($urandom_range(0, 9) < 6)
                begin
                    queue_byte(OPTIONS_END, 1'b0);
                    repeat ($urandom_range(0, 3))
                        queue_byte(8'($urandom), 1'b0);
                end
            end
            else
            begin
                n = $urandom_range(1, 10);
                for (i = 0; i < n; i++)
                    queue_byte(8'($urandom), (i == 0) || ($urandom_range(0, 7) == 0));
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        // Anything still predicted never came out.
        mismatches = mismatches + expected_words.size();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : watchdog
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
